// File: design/pnt_pkg.sv
// package for the perceptron neuron: controller states, command and status structs,
// activation and request codes, saturation and activation table builders; no dependencies
package pnt_pkg;

  localparam int MAX_INPUTS = 8;
  localparam int DEF_INPUTS = 8;
  localparam int DEF_FRAC_BITS = 12;
  localparam int DEF_ACT_TABLE_DEPTH = 256;
  localparam int LEAKY_NUM = 41;
  localparam int LEAKY_SHIFT = 12;
  localparam int BIAS_INDEX = 8;

  localparam logic [2:0] ACT_LINEAR = 3'd0;
  localparam logic [2:0] ACT_SIGMOID = 3'd1;
  localparam logic [2:0] ACT_TANH = 3'd2;
  localparam logic [2:0] ACT_RELU = 3'd3;
  localparam logic [2:0] ACT_LEAKY = 3'd4;
  localparam logic [2:0] ACT_STEP = 3'd6;

  localparam logic [2:0] REQ_INFER = 3'd0;
  localparam logic [2:0] REQ_INFER_BIAS = 3'd1;
  localparam logic [2:0] REQ_TRAIN = 3'd2;
  localparam logic [2:0] REQ_WRITE = 3'd3;
  localparam logic [2:0] REQ_READ = 3'd4;

  localparam logic [2:0] ACT_MODE_RESET = 3'd1;
  localparam logic [15:0] LEARNING_RATE_RESET = 16'd655;

  localparam logic REG_ACT_MODE = 1'b0;
  localparam logic REG_LEARNING_RATE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_ACT,
    S_ERR,
    S_UPD,
    S_BIAS,
    S_RW,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mac;
    logic act;
    logic err;
    logic upd;
    logic bias;
    logic rw;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic ok;
  } stat_t;

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -64'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // shift-subtract quotient for table building, both operands nonnegative
  function automatic longint cdiv(input longint n, input longint d);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int b = 62; b >= 0; b--) begin
      r = (r << 1) | ((n >>> b) & 1);
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 1;
      end
    end
    return q;
  endfunction

  // e^(-f/65536) in q30, series expansion
  function automatic longint exp_frac(input longint f);
    longint sum;
    longint term;
    sum = longint'(1) << 30;
    term = longint'(1) << 30;
    for (int k = 1; k <= 18; k++) begin
      term = cdiv((term * f) >>> 16, longint'(k));
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic longint exp_neg(input longint t);
    longint r;
    longint e1;
    longint n;
    r = exp_frac(t & 64'hffff);
    e1 = exp_frac(65536);
    n = t >>> 16;
    while (n > 0) begin
      r = (r * e1) >>> 30;
      n = n - 1;
    end
    return r;
  endfunction

  function automatic longint tab_point(input int i, input int depth);
    return -8 * 65536 + cdiv(longint'(2 * i + 1) * 8 * 65536, longint'(depth));
  endfunction

  function automatic logic signed [15:0] sig_entry(input int i, input int depth, input int frac);
    longint x;
    longint a;
    longint e;
    longint s;
    x = tab_point(i, depth);
    a = (x < 0) ? -x : x;
    e = exp_neg(a);
    s = cdiv(longint'(1) << 60, (longint'(1) << 30) + e);
    if (x < 0) begin
      s = (longint'(1) << 30) - s;
    end
    s = (s + (longint'(1) << (29 - frac))) >>> (30 - frac);
    return sat16(64'(s));
  endfunction

  function automatic logic signed [15:0] tanh_entry(input int i, input int depth,
                                                    input int frac);
    longint x;
    longint a;
    longint e2;
    longint t;
    x = tab_point(i, depth);
    a = (x < 0) ? -x : x;
    e2 = exp_neg(2 * a);
    t = cdiv(((longint'(1) << 30) - e2) << 30, (longint'(1) << 30) + e2);
    t = (t + (longint'(1) << (29 - frac))) >>> (30 - frac);
    if (x < 0) begin
      t = -t;
    end
    return sat16(64'(t));
  endfunction

endpackage

// File: design/pnt_ctrl.sv
// controller state machine of the perceptron neuron
// uses pnt_pkg for states and command/status structs
module pnt_ctrl import pnt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] req_type,
  output logic       out_valid,
  input  logic       out_ready,
  output cmd_t       cmd,
  input  stat_t      stat
);

  state_t state;
  state_t state_next;
  logic [2:0] req;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= req_type;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (req_type inside {REQ_INFER, REQ_INFER_BIAS, REQ_TRAIN}) begin
            state_next = S_MAC;
          end else begin
            state_next = S_RW;
          end
        end
      end
      S_MAC: begin
        cmd.mac = 1'b1;
        if (stat.last) state_next = S_ACT;
      end
      S_ACT: begin
        cmd.act = 1'b1;
        state_next = (req == REQ_TRAIN) ? S_ERR : S_DONE;
      end
      S_ERR: begin
        // invalid mode leaves the weights alone
        if (stat.ok) begin
          cmd.err = 1'b1;
          state_next = S_UPD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        if (stat.last) state_next = S_BIAS;
      end
      S_BIAS: begin
        cmd.bias = 1'b1;
        state_next = S_DONE;
      end
      S_RW: begin
        cmd.rw = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid_next = cmd.out_load | (out_valid & ~out_ready);

endmodule

// File: design/pnt_datapath.sv
// datapath of the perceptron neuron: weight registers, shared mac, activation,
// delta-rule update and the result register; uses pnt_pkg
module pnt_datapath import pnt_pkg::*; #(
  parameter int INPUTS = DEF_INPUTS,
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int ACT_TABLE_DEPTH = DEF_ACT_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic [2:0]         activation_mode,
  input  logic [15:0]        learning_rate,
  input  logic [2:0]         req_type,
  input  logic signed [15:0] x [MAX_INPUTS],
  input  logic signed [15:0] target,
  input  logic [3:0]         weight_index,
  input  logic signed [15:0] load_value,
  output logic signed [15:0] out_value,
  output logic               status
);

  localparam int IW = (INPUTS > 1) ? $clog2(INPUTS) : 1;
  localparam int ACC_W = 32 + $clog2(INPUTS + 1) + 1;
  localparam int UW = FRAC_BITS + 4;
  localparam int TIW = $clog2(ACT_TABLE_DEPTH);
  localparam int PW = 34;
  localparam int DW = PW + 16;
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] LIM = ACC_W'(8) <<< FRAC_BITS;
  localparam logic signed [15:0] ONE_F = 16'(1) <<< FRAC_BITS;

  logic signed [15:0] w [INPUTS];
  logic signed [15:0] bias;
  logic signed [15:0] x_q [INPUTS];
  logic signed [15:0] tgt_q;
  logic [3:0]         idx_q;
  logic signed [15:0] load_q;
  logic [2:0]         req_q;
  logic signed [ACC_W-1:0] acc;
  logic [IW-1:0]      cnt;
  logic signed [15:0] res_q;
  logic               ok_q;
  logic signed [PW-1:0] p_q;

  logic signed [15:0] sig_tab [ACT_TABLE_DEPTH];
  logic signed [15:0] tanh_tab [ACT_TABLE_DEPTH];

  for (genvar gi = 0; gi < ACT_TABLE_DEPTH; gi++) begin : g_tab
    localparam logic signed [15:0] SV = sig_entry(gi, ACT_TABLE_DEPTH, FRAC_BITS);
    localparam logic signed [15:0] TV = tanh_entry(gi, ACT_TABLE_DEPTH, FRAC_BITS);
    assign sig_tab[gi] = SV;
    assign tanh_tab[gi] = TV;
  end

  // activation of the rounded total
  logic signed [ACC_W-1:0] total;
  logic signed [ACC_W-1:0] clamp;
  logic [UW-1:0]           tab_u;
  logic [UW+TIW:0]         tab_p;
  logic [TIW-1:0]          tab_idx;
  logic signed [ACC_W+6:0] lk_p;
  logic signed [ACC_W+6:0] lk;
  logic signed [15:0]      act_val;
  logic                    act_ok;

  always_comb begin
    total = (acc + RND) >>> FRAC_BITS;
    if (total < -LIM) begin
      clamp = -LIM;
    end else if (total > LIM - ACC_W'(1)) begin
      clamp = LIM - ACC_W'(1);
    end else begin
      clamp = total;
    end
    tab_u = UW'(clamp + LIM);
    tab_p = (UW + TIW + 1)'(tab_u) * (UW + TIW + 1)'(ACT_TABLE_DEPTH);
    tab_idx = tab_p[UW+TIW-1:UW];
    lk_p = (ACC_W + 7)'(total) * (ACC_W + 7)'(LEAKY_NUM);
    lk = (lk_p + ((ACC_W + 7)'(1) <<< (LEAKY_SHIFT - 1))) >>> LEAKY_SHIFT;
    act_ok = 1'b1;
    case (activation_mode)
      ACT_LINEAR:  act_val = sat16(64'(total));
      ACT_SIGMOID: act_val = sig_tab[tab_idx];
      ACT_TANH:    act_val = tanh_tab[tab_idx];
      ACT_RELU:    act_val = (total > 0) ? sat16(64'(total)) : 16'sd0;
      ACT_LEAKY:   act_val = (total > 0) ? sat16(64'(total)) : sat16(64'(lk));
      ACT_STEP:    act_val = (total > 0) ? ONE_F : 16'sd0;
      default: begin
        act_val = 16'sd0;
        act_ok = 1'b0;
      end
    endcase
  end

  // mac and update arithmetic
  logic signed [31:0]   prod;
  logic signed [16:0]   err;
  logic signed [PW-1:0] p_next;
  logic signed [DW-1:0] pw;
  logic signed [DW-1:0] dw;
  logic signed [DW-1:0] wsum;
  logic signed [PW-1:0] db;
  logic signed [PW:0]   bsum;
  logic signed [15:0]   rd_val;
  logic signed [15:0]   bsel;

  always_comb begin
    prod = w[cnt] * x_q[cnt];
    err = 17'(tgt_q) - 17'(res_q);
    p_next = PW'($signed({1'b0, learning_rate})) * PW'(err);
    pw = DW'(p_q) * DW'(x_q[cnt]);
    dw = (pw + (DW'(1) <<< (15 + FRAC_BITS))) >>> (16 + FRAC_BITS);
    wsum = DW'(w[cnt]) + dw;
    db = (p_q + (PW'(1) <<< 15)) >>> 16;
    bsum = (PW + 1)'(bias) + (PW + 1)'(db);
    if (idx_q == 4'(BIAS_INDEX)) begin
      rd_val = bias;
    end else if (idx_q < 4'(INPUTS)) begin
      rd_val = w[idx_q[IW-1:0]];
    end else begin
      rd_val = 16'sd0;
    end
    bsel = (req_type == REQ_INFER_BIAS) ? load_value : bias;
  end

  assign stat.last = (cnt == IW'(INPUTS - 1));
  assign stat.ok = ok_q;

  // weights and bias
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < INPUTS; i++) w[i] <= 16'sd0;
      bias <= 16'sd0;
    end else if (cmd.upd) begin
      w[cnt] <= sat16(64'(wsum));
    end else if (cmd.bias) begin
      bias <= sat16(64'(bsum));
    end else if (cmd.rw && req_q == REQ_WRITE) begin
      if (idx_q == 4'(BIAS_INDEX)) begin
        bias <= load_q;
      end else if (idx_q < 4'(INPUTS)) begin
        w[idx_q[IW-1:0]] <= load_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < INPUTS; i++) x_q[i] <= x[i];
      tgt_q <= target;
      idx_q <= weight_index;
      load_q <= load_value;
      req_q <= req_type;
      acc <= ACC_W'(bsel) <<< FRAC_BITS;
    end else if (cmd.mac) begin
      acc <= acc + ACC_W'(prod);
    end
    if (cmd.load || cmd.err) begin
      cnt <= '0;
    end else if (cmd.mac || cmd.upd) begin
      cnt <= stat.last ? '0 : cnt + IW'(1);
    end
    if (cmd.act) begin
      res_q <= act_val;
      ok_q <= act_ok;
    end else if (cmd.rw) begin
      res_q <= (req_q == REQ_READ) ? rd_val : 16'sd0;
      ok_q <= 1'b1;
    end
    if (cmd.err) begin
      p_q <= p_next;
    end
    if (cmd.out_load) begin
      out_value <= ok_q ? res_q : 16'sd0;
      status <= ~ok_q;
    end
  end

endmodule

// File: design/perceptron_neuron_train.sv
// top level of the perceptron neuron with delta-rule training
// holds the config registers and joins pnt_ctrl and pnt_datapath; uses pnt_pkg
//
// usage:
//   input channel (in_valid/in_ready) takes one request item: infer, infer with
//   a given bias, train, write a weight or read one back
//   output channel (out_valid/out_ready) returns one item per request:
//   out_value and status (1 when the activation mode is invalid)
//   apb port writes activation_mode at 0x0 and learning_rate at 0x4
// timing:
//   one item at a time; the shared multiplier walks the weights one per cycle
//   infer: mac pass, activation, then the result loads into the output register
//   train: mac pass, activation, error, update pass, bias, result
//   write/read: register access, then the result
//   in_ready is high again in the cycle out_valid rises, so the next item is
//   taken only once the last one has reached the output register
// reset: weights and bias clear to zero, mode goes to sigmoid, rate to 655
// stall: a result waits in the output register; the next item may be accepted
//   and worked on, and its result loads once the waiting one is taken
module perceptron_neuron_train import pnt_pkg::*; #(
  parameter int INPUTS = DEF_INPUTS,
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int ACT_TABLE_DEPTH = DEF_ACT_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input item
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         req_type,
  input  logic signed [15:0] x0,
  input  logic signed [15:0] x1,
  input  logic signed [15:0] x2,
  input  logic signed [15:0] x3,
  input  logic signed [15:0] x4,
  input  logic signed [15:0] x5,
  input  logic signed [15:0] x6,
  input  logic signed [15:0] x7,
  input  logic signed [15:0] target,
  input  logic [3:0]         weight_index,
  input  logic signed [15:0] load_value,
  // result item
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_value,
  output logic               status
);

  logic [2:0]  activation_mode;
  logic [15:0] learning_rate;
  logic        cfg_wr;
  cmd_t        cmd;
  stat_t       stat;
  logic signed [15:0] x [MAX_INPUTS];

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  // config registers, word select on paddr[2]
  always_ff @(posedge clk) begin
    if (rst) begin
      activation_mode <= ACT_MODE_RESET;
      learning_rate <= LEARNING_RATE_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_ACT_MODE:      activation_mode <= pwdata[2:0];
        REG_LEARNING_RATE: learning_rate <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ACT_MODE:      prdata = {29'd0, activation_mode};
      REG_LEARNING_RATE: prdata = {16'd0, learning_rate};
      default:           prdata = 32'd0;
    endcase
  end

  assign x[0] = x0;
  assign x[1] = x1;
  assign x[2] = x2;
  assign x[3] = x3;
  assign x[4] = x4;
  assign x[5] = x5;
  assign x[6] = x6;
  assign x[7] = x7;

  pnt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  pnt_datapath #(
    .INPUTS          (INPUTS),
    .FRAC_BITS       (FRAC_BITS),
    .ACT_TABLE_DEPTH (ACT_TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .activation_mode (activation_mode),
    .learning_rate   (learning_rate),
    .req_type        (req_type),
    .x               (x),
    .target          (target),
    .weight_index    (weight_index),
    .load_value      (load_value),
    .out_value       (out_value),
    .status          (status)
  );

  // one item in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while one is in flight");

  // an error result carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (out_value == 16'sd0))
    else $error("error status with nonzero value");

  // a new result only loads when the output side is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(out_value))
    else $error("waiting result overwritten");

endmodule

// File: tb/pnt_checker.sv
// result checker for perceptron_neuron_train: predicts each result from the accepted
// request items and compares it with the output channel; uses pnt_pkg
module pnt_checker import pnt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         req_type,
  input  logic signed [15:0] x0,
  input  logic signed [15:0] x1,
  input  logic signed [15:0] x2,
  input  logic signed [15:0] x3,
  input  logic signed [15:0] x4,
  input  logic signed [15:0] x5,
  input  logic signed [15:0] x6,
  input  logic signed [15:0] x7,
  input  logic signed [15:0] target,
  input  logic [3:0]         weight_index,
  input  logic signed [15:0] load_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_value,
  input  logic               status,
  output int                 fail_count,
  output int                 pending,
  output int                 results_seen
);

  typedef struct packed {
    logic signed [15:0] value;
    logic               bad_mode;
  } neuron_result_t;

  logic signed [15:0] sig_lut [256];
  logic signed [15:0] tanh_lut [256];
  logic [2:0]         mode_q;
  logic [15:0]        rate_q;
  longint             weights [8];
  longint             bias_q;
  neuron_result_t     result_fifo [$];

  function automatic longint rnd_shift(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint sig_exp(input longint f);
    longint sum, term;
    sum = longint'(1) << 30;
    term = sum;
    for (int k = 1; k <= 18; k++) begin
      term = ((term * f) >>> 16) / k;
      if (k & 1) sum -= term;
      else sum += term;
    end
    return sum;
  endfunction

  function automatic longint neg_exp(input longint t);
    longint r, e1, n;
    r = sig_exp(t & 64'hffff);
    e1 = sig_exp(65536);
    n = t >>> 16;
    while (n > 0) begin
      r = (r * e1) >>> 30;
      n--;
    end
    return r;
  endfunction

  function automatic int lut_index(input longint total);
    longint c;
    c = total;
    if (c < -8 * 4096) c = -8 * 4096;
    if (c > 8 * 4096 - 1) c = 8 * 4096 - 1;
    return int'(((c + 8 * 4096) * 256) / (16 * 4096));
  endfunction

  // activation of a rounded total; bad_mode set for codes 5 and 7
  function automatic void activate_total(input longint total, output longint res,
                                         output logic bad_mode);
    bad_mode = 1'b0;
    case (mode_q)
      ACT_LINEAR:  res = clip16(total);
      ACT_SIGMOID: res = sig_lut[lut_index(total)];
      ACT_TANH:    res = tanh_lut[lut_index(total)];
      ACT_RELU:    res = total > 0 ? clip16(total) : 0;
      ACT_LEAKY:   res = total > 0 ? clip16(total) : clip16(rnd_shift(total * LEAKY_NUM, 12));
      ACT_STEP:    res = total > 0 ? 4096 : 0;
      default: begin
        res = 0;
        bad_mode = 1'b1;
      end
    endcase
  endfunction

  function automatic neuron_result_t neuron_step(input logic [2:0] req,
                                                 input longint xv [8], input longint tgt,
                                                 input logic [3:0] idx, input longint load);
    neuron_result_t r;
    longint acc, res, err;
    logic bad;
    res = 0;
    bad = 1'b0;
    if (req == REQ_INFER || req == REQ_INFER_BIAS || req == REQ_TRAIN) begin
      acc = ((req == REQ_INFER_BIAS) ? load : bias_q) * 4096;
      for (int i = 0; i < 8; i++) acc += weights[i] * xv[i];
      activate_total(rnd_shift(acc, 12), res, bad);
      if (req == REQ_TRAIN && !bad) begin
        err = tgt - res;
        for (int i = 0; i < 8; i++)
          weights[i] = clip16(weights[i] + rnd_shift(longint'(rate_q) * err * xv[i], 28));
        bias_q = clip16(bias_q + rnd_shift(longint'(rate_q) * err, 16));
      end
    end else if (req == REQ_WRITE) begin
      if (idx == BIAS_INDEX) bias_q = load;
      else if (idx < 8) weights[idx] = load;
    end else if (req == REQ_READ) begin
      if (idx == BIAS_INDEX) res = bias_q;
      else if (idx < 8) res = weights[idx];
    end
    r.value = bad ? 16'sd0 : res[15:0];
    r.bad_mode = bad;
    return r;
  endfunction

  // tables built locally from the series so the package builders are not reused
  initial begin
    longint x, a, e, s, e2, t;
    for (int i = 0; i < 256; i++) begin
      x = -8 * 65536 + (longint'(2 * i + 1) * 8 * 65536) / 256;
      a = x < 0 ? -x : x;
      e = neg_exp(a);
      s = (longint'(1) << 60) / ((longint'(1) << 30) + e);
      e2 = neg_exp(2 * a);
      t = (((longint'(1) << 30) - e2) << 30) / ((longint'(1) << 30) + e2);
      if (x < 0) s = (longint'(1) << 30) - s;
      s = (s + (longint'(1) << 17)) >>> 18;
      t = (t + (longint'(1) << 17)) >>> 18;
      if (x < 0) t = -t;
      sig_lut[i] = 16'(clip16(s));
      tanh_lut[i] = 16'(clip16(t));
    end
  end

  always @(posedge clk) begin
    longint xv [8];
    neuron_result_t exp_r;
    if (rst) begin
      mode_q <= ACT_MODE_RESET;
      rate_q <= LEARNING_RATE_RESET;
      for (int i = 0; i < 8; i++) weights[i] = 0;
      bias_q = 0;
      result_fifo.delete();
      fail_count <= 0;
      results_seen <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_LEARNING_RATE) rate_q <= pwdata[15:0];
        else mode_q <= pwdata[2:0];
      end
      if (in_valid && in_ready) begin
        xv = '{x0, x1, x2, x3, x4, x5, x6, x7};
        result_fifo.push_back(neuron_step(req_type, xv, target, weight_index, load_value));
      end
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (result_fifo.size() == 0) begin
          $error("result item with nothing expected: out_value %0d status %0d",
                 out_value, status);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = result_fifo.pop_front();
          if (out_value !== exp_r.value || status !== exp_r.bad_mode) begin
            if (out_value !== exp_r.value)
              $error("out_value expected %0d actual %0d", exp_r.value, out_value);
            if (status !== exp_r.bad_mode)
              $error("status expected %0d actual %0d", exp_r.bad_mode, status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= result_fifo.size();
  end

endmodule

// File: tb/tb_perceptron_neuron_train.sv
// testbench top for perceptron_neuron_train: clock, reset, apb writes, request and
// result traffic, verdict; depends on pnt_pkg, pnt_checker and the block itself
module tb_perceptron_neuron_train;
  import pnt_pkg::*;

  logic               clk;
  logic               rst;
  logic               psel, penable, pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid, in_ready;
  logic [2:0]         req_type;
  logic signed [15:0] x0, x1, x2, x3, x4, x5, x6, x7, target, load_value;
  logic [3:0]         weight_index;
  logic               out_valid, out_ready;
  logic signed [15:0] out_value;
  logic               status;
  int                 fail_count, pending, results_seen;
  int                 idle_cycles;
  int                 items_sent;
  bit                 hold_long;  // ask the receiver for one long hold-off
  bit                 stim_done;

  localparam int WATCHDOG_LIMIT = 20000;

  perceptron_neuron_train i_dut (.*);

  pnt_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: cycles with nothing accepted anywhere
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_perceptron_neuron_train: FAIL");
      $finish;
    end
  end

  // receiver: random stalls, mostly short, now and then long, plus one forced hold-off
  initial begin
    int n;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_long = 1'b0;
      end
      n = $urandom_range(0, 99);
      if (n < 40) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end else if (n < 90) begin
        out_ready <= ~out_ready;
        @(negedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(5, 60)) @(negedge clk);
      end
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // both registers changed only with the block drained
  task automatic set_neuron_config(input logic [2:0] mode, input logic [15:0] rate);
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    apb_write(3'(4 * REG_ACT_MODE), 32'(mode));
    apb_write(3'(4 * REG_LEARNING_RATE), 32'(rate));
  endtask

  // hand over one request item, then an optional random gap
  task automatic send_request(input logic [2:0] req, input logic signed [15:0] xs [8],
                              input logic signed [15:0] tgt, input logic [3:0] idx,
                              input logic signed [15:0] load, input bit gaps);
    int g;
    req_type <= req;
    {x0, x1, x2, x3, x4, x5, x6, x7} <= {xs[0], xs[1], xs[2], xs[3],
                                         xs[4], xs[5], xs[6], xs[7]};
    target <= tgt;
    weight_index <= idx;
    load_value <= load;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (gaps) begin
      g = $urandom_range(0, 99);
      if (g >= 60) begin
        in_valid <= 1'b0;
        repeat ((g < 95) ? $urandom_range(1, 4) : $urandom_range(10, 80)) @(negedge clk);
      end
    end
  endtask

  function automatic logic signed [15:0] rand_q(input int kind);
    case (kind)
      0: return 16'($urandom);
      1: return 16'sh7fff;
      2: return 16'sh8000;
      default: return 16'($signed($urandom_range(0, 16384)) - 8192);
    endcase
  endfunction

  task automatic random_request(input bit small_weights);
    logic signed [15:0] xs [8];
    logic [2:0] req;
    int k;
    k = $urandom_range(0, 99);
    for (int i = 0; i < 8; i++) xs[i] = rand_q(small_weights ? 3 : $urandom_range(0, 6));
    if (k < 25) req = REQ_INFER;
    else if (k < 35) req = REQ_INFER_BIAS;
    else if (k < 70) req = REQ_TRAIN;
    else if (k < 82) req = REQ_WRITE;
    else if (k < 95) req = REQ_READ;
    else req = 3'($urandom_range(5, 7));
    send_request(req, xs, rand_q($urandom_range(0, 6)), 4'($urandom_range(0, 15)),
                 rand_q(small_weights ? 3 : $urandom_range(0, 6)), 1'b1);
  endtask

  logic signed [15:0] dir_x [8];
  logic [2:0] mode_list [7] = '{ACT_LINEAR, ACT_SIGMOID, ACT_TANH, ACT_RELU,
                                ACT_LEAKY, ACT_STEP, 3'd5};
  logic [15:0] rate_list [7] = '{16'd0, 16'd655, 16'hffff, 16'd4000, 16'd100,
                                16'd20000, 16'd1};

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; req_type = '0; weight_index = '0;
    {x0, x1, x2, x3, x4, x5, x6, x7, target, load_value} = '0;
    hold_long = 1'b0;
    stim_done = 1'b0;
    items_sent = 0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // directed: reset values read back, writes, extremes, all five request types and codes 5 and 7
    for (int i = 0; i < 8; i++) dir_x[i] = 16'sh1000;
    send_request(REQ_READ, dir_x, 0, 4'd3, 0, 1'b0);
    send_request(REQ_INFER, dir_x, 0, 0, 0, 1'b0);
    for (int i = 0; i < 9; i++)
      send_request(REQ_WRITE, dir_x, 0, 4'(i), (i & 1) ? 16'sh7fff : 16'sh8000, 1'b0);
    send_request(REQ_WRITE, dir_x, 0, 4'd12, 16'sh1234, 1'b0);
    send_request(REQ_READ, dir_x, 0, 4'd8, 0, 1'b0);
    send_request(REQ_READ, dir_x, 0, 4'd15, 0, 1'b0);
    send_request(REQ_INFER, dir_x, 0, 0, 0, 1'b0);
    for (int i = 0; i < 8; i++) dir_x[i] = (i & 1) ? 16'sh8000 : 16'sh7fff;
    send_request(REQ_INFER_BIAS, dir_x, 0, 0, 16'sh7fff, 1'b0);
    send_request(REQ_TRAIN, dir_x, 16'sh7fff, 0, 0, 1'b0);
    send_request(REQ_TRAIN, dir_x, 16'sh8000, 0, 0, 1'b0);
    send_request(3'd5, dir_x, 0, 0, 0, 1'b0);
    send_request(3'd7, dir_x, 0, 0, 0, 1'b0);

    // random phases: each mode and rate, extremes included
    for (int p = 0; p < 14; p++) begin
      in_valid <= 1'b0;
      set_neuron_config((p == 13) ? 3'd7 : mode_list[p % 7], rate_list[(p * 3) % 7]);
      for (int n = 0; n < 120; n++) begin
        if (p == 4 && n == 10) hold_long = 1'b1;
        random_request(($urandom_range(0, 3) != 0) && (mode_list[p % 7] != ACT_LINEAR));
      end
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    @(negedge clk);
    while (!stim_done || pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    $display("sent %0d request items over all activation modes and rate settings,", items_sent);
    $display("checked %0d result items including a long output hold-off", results_seen);
    if (fail_count == 0)
      $display("tb_perceptron_neuron_train: PASS");
    else
      $display("tb_perceptron_neuron_train: FAIL");
    $finish;
  end

endmodule

// File: filelist.f
design/pnt_pkg.sv
design/pnt_ctrl.sv
design/pnt_datapath.sv
design/perceptron_neuron_train.sv
tb/pnt_checker.sv
tb/tb_perceptron_neuron_train.sv
